FILE: rtl/core/pbc_pkg.sv
// Shared types, constants and helper functions of the pileup base counter.
// Used by every module of the block; depends on nothing.

package pbc_pkg;

  localparam int MAX_REF_LEN = 4096;
  localparam int ADDR_W      = $clog2(MAX_REF_LEN);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int CNT_W       = 16;
  localparam int NUM_BASES   = 5;
  localparam int BIDX_W      = 3;

  localparam logic [LEN_W-1:0] REF_LEN_RESET = LEN_W'(MAX_REF_LEN);

  // Request kinds.
  localparam logic [2:0] REQ_MATCH    = 3'd0;
  localparam logic [2:0] REQ_MISMATCH = 3'd1;
  localparam logic [2:0] REQ_DELETION = 3'd2;
  localparam logic [2:0] REQ_SKIP     = 3'd3;
  localparam logic [2:0] REQ_READOUT  = 3'd4;
  localparam logic [2:0] REQ_CLEAR    = 3'd5;

  // Result status codes.
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_BASE  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // Base indexes.
  localparam logic [BIDX_W-1:0] BASE_A    = 3'd0;
  localparam logic [BIDX_W-1:0] BASE_C    = 3'd1;
  localparam logic [BIDX_W-1:0] BASE_G    = 3'd2;
  localparam logic [BIDX_W-1:0] BASE_T    = 3'd3;
  localparam logic [BIDX_W-1:0] BASE_GAP  = 3'd4;
  localparam logic [BIDX_W-1:0] BASE_NONE = 3'd7;

  // One table entry: five base counters, coverage and the mismatch mark.
  typedef struct packed {
    logic                                mark;
    logic [CNT_W-1:0]                    depth;
    logic [NUM_BASES-1:0][CNT_W-1:0]     counts;
  } entry_t;

  // Item held between acceptance and write-back.
  typedef struct packed {
    logic [2:0] req;
    logic [7:0] base_char;
    logic       range_err;
  } item_t;

  // Result fields of one item.
  typedef struct packed {
    logic [7:0]  base;
    logic [15:0] count;
    logic [15:0] cov;
    logic        mark;
    logic [1:0]  err;
  } result_t;

  function automatic logic [BIDX_W-1:0] base_index(input logic [7:0] c);
    logic [BIDX_W-1:0] idx;
    case (c)
      8'h41, 8'h61: idx = BASE_A;
      8'h43, 8'h63: idx = BASE_C;
      8'h47, 8'h67: idx = BASE_G;
      8'h54, 8'h74: idx = BASE_T;
      8'h2D:        idx = BASE_GAP;
      default:      idx = BASE_NONE;
    endcase
    return idx;
  endfunction

  function automatic logic [7:0] base_letter(input logic [BIDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      BASE_A:  c = 8'h41;
      BASE_C:  c = 8'h43;
      BASE_G:  c = 8'h47;
      BASE_T:  c = 8'h54;
      default: c = 8'h2D;
    endcase
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: rtl/core/pbc_table_ram.sv
// Per-position pileup table: one write port, one read port, registered read.
// Depends on pbc_pkg for the entry type and depth.

module pbc_table_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [pbc_pkg::ADDR_W-1:0]  wr_addr,
  input  pbc_pkg::entry_t             wr_data,
  input  logic                        rd_en,
  input  logic [pbc_pkg::ADDR_W-1:0]  rd_addr,
  output pbc_pkg::entry_t             rd_data
);

  pbc_pkg::entry_t mem [pbc_pkg::MAX_REF_LEN];
  pbc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/pbc_update.sv
// Modify step of the read-modify-write: new entry and result for one item.
// Depends on pbc_pkg for types, request codes and counter helpers.

module pbc_update (
  input  pbc_pkg::item_t    item,
  input  pbc_pkg::entry_t   old_entry,
  output pbc_pkg::entry_t   new_entry,
  output logic              wr_needed,
  output pbc_pkg::result_t  result
);

  logic [pbc_pkg::BIDX_W-1:0] idx;
  logic                       idx_ok;
  logic [pbc_pkg::BIDX_W-1:0] best_idx;
  logic [pbc_pkg::CNT_W-1:0]  best_cnt;

  assign idx    = pbc_pkg::base_index(item.base_char);
  assign idx_ok = (idx != pbc_pkg::BASE_NONE);

  // Most common base; the reference base wins ties since it is the start value.
  always_comb begin
    best_idx = idx;
    best_cnt = old_entry.counts[idx];
    for (int i = 0; i < pbc_pkg::NUM_BASES; i++) begin
      if (old_entry.counts[i] > best_cnt) begin
        best_cnt = old_entry.counts[i];
        best_idx = pbc_pkg::BIDX_W'(i);
      end
    end
  end

  always_comb begin
    new_entry = old_entry;
    wr_needed = 1'b0;
    result    = '0;
    if (item.req > pbc_pkg::REQ_CLEAR) begin
      result = '0;
    end else if (item.range_err) begin
      result.err = pbc_pkg::ERR_RANGE;
    end else begin
      case (item.req) inside
        pbc_pkg::REQ_MATCH, pbc_pkg::REQ_MISMATCH: begin
          if (!idx_ok) begin
            result.err = pbc_pkg::ERR_BASE;
          end else begin
            new_entry.counts[idx] = pbc_pkg::sat_inc(old_entry.counts[idx]);
            new_entry.depth       = pbc_pkg::sat_inc(old_entry.depth);
            if (item.req == pbc_pkg::REQ_MISMATCH) begin
              new_entry.mark = 1'b1;
            end
            wr_needed = 1'b1;
          end
        end
        pbc_pkg::REQ_DELETION: begin
          new_entry.counts[pbc_pkg::BASE_GAP] =
            pbc_pkg::sat_inc(old_entry.counts[pbc_pkg::BASE_GAP]);
          new_entry.depth = pbc_pkg::sat_inc(old_entry.depth);
          new_entry.mark  = 1'b1;
          wr_needed       = 1'b1;
        end
        pbc_pkg::REQ_SKIP: begin
          new_entry.depth = pbc_pkg::sat_inc(old_entry.depth);
          wr_needed       = 1'b1;
        end
        pbc_pkg::REQ_READOUT: begin
          if (!idx_ok) begin
            result.err = pbc_pkg::ERR_BASE;
          end else begin
            result.base  = pbc_pkg::base_letter(best_idx);
            result.count = 16'(best_cnt);
            result.cov   = 16'(old_entry.depth);
            result.mark  = old_entry.mark;
          end
        end
        default: begin
          new_entry = '0;
          wr_needed = 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/pileup_base_counter.sv
// Top level of the pileup base counter: handshakes, sequencer, output register.
// Depends on pbc_pkg, pbc_table_ram and pbc_update.
//
//  Channel   Group     Direction  Payload (low bit first)
//  --------  --------  ---------  ---------------------------------------------
//  input     in_*      slave      tuser: req_type; tdata: position, base_char
//  result    out_*     master     tuser: error_code; tdata: consensus_base,
//                                 consensus_count, coverage, mismatch_mark
//  config    cfg_*     write      ref_length (13 bits)
//
// Each item is first read from the table memory, then modified, written back and
// its result loaded into the result register; the modify step waits while the
// result register is full. The block takes no new item until the last is done.
// After reset a clearing pass zeroes all 4096 entries, one per cycle; in_tready
// first rises when the clearing pass is done.
// A waiting result does not block the next beat; only the write-back of that
// next item holds until the result register is free.

module pileup_base_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [11:0] position, [19:12] base_char, rest zero
  input  logic [2:0]  in_tuser,    // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] consensus_base, [23:8] consensus_count,
                                   // [39:24] coverage, [40] mismatch_mark, rest zero
  output logic [1:0]  out_tuser,   // [1:0] error_code
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data  // ref_length
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_MODIFY = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [pbc_pkg::ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [pbc_pkg::LEN_W-1:0]    ref_len_r;
  pbc_pkg::item_t               item_r;
  logic [pbc_pkg::ADDR_W-1:0]   pos_r;
  logic                         out_valid_r, out_valid_nxt;
  pbc_pkg::result_t             out_res_r;

  logic                         in_fire;
  logic                         out_free;
  logic                         commit;
  logic [pbc_pkg::ADDR_W-1:0]   in_pos;
  pbc_pkg::entry_t              rd_entry;
  pbc_pkg::entry_t              upd_entry;
  logic                         upd_wr;
  pbc_pkg::result_t             upd_res;
  logic                         ram_wr_en;
  logic [pbc_pkg::ADDR_W-1:0]   ram_wr_addr;
  pbc_pkg::entry_t              ram_wr_data;

  assign in_pos    = in_tdata[pbc_pkg::ADDR_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  // The modify cycle completes only when the result register can take the result.
  assign commit    = (state_r == ST_MODIFY) && out_free;

  // Sequencer: clearing pass, then one item at a time through read and modify.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + pbc_pkg::ADDR_W'(1);
        if (clr_cnt_r == pbc_pkg::ADDR_W'(pbc_pkg::MAX_REF_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      ref_len_r <= pbc_pkg::REF_LEN_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_wr_en) begin
        ref_len_r <= cfg_wr_data;
      end
    end
  end

  // Capture the item; the range check against ref_length is done here.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.req       <= in_tuser;
      item_r.base_char <= in_tdata[19:12];
      item_r.range_err <= ({1'b0, in_pos} >= ref_len_r);
      pos_r            <= in_pos;
    end
  end

  pbc_update u_update (
    .item      (item_r),
    .old_entry (rd_entry),
    .new_entry (upd_entry),
    .wr_needed (upd_wr),
    .result    (upd_res)
  );

  // The write port serves the clearing pass and the write-back.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_cnt_r;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = commit && upd_wr;
      ram_wr_addr = pos_r;
      ram_wr_data = upd_entry;
    end
  end

  pbc_table_ram u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (in_fire),
    .rd_addr (in_pos),
    .rd_data (rd_entry)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r <= upd_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r.mark, out_res_r.cov, out_res_r.count, out_res_r.base};
  assign out_tuser  = out_res_r.err;

endmodule

FILE: tb/sv/pileup_base_counter_tb.sv
// Self-checking testbench for the pileup base counter: a directed table and random
// traffic under several reference lengths, scored against an in-bench model or a
// directed row's own expectation. Depends on pbc_pkg and the pileup_base_counter RTL.
`timescale 1ns / 1ps

module pileup_base_counter_tb;
  import pbc_pkg::*;

  // The block clears its whole table after reset, so the watchdog must tolerate
  // the wait for the first beat that this causes.
  localparam int IDLE_LIMIT = 20000;
  // Extra wait that covers the write-back of the last item before the length
  // register changes or the run ends.
  localparam int SETTLE_CYCLES = 8;

  // Request kinds the block treats as no-ops.
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  localparam logic [7:0] CH_A   = "A";
  localparam logic [7:0] CH_C   = "C";
  localparam logic [7:0] CH_G   = "G";
  localparam logic [7:0] CH_T   = "T";
  localparam logic [7:0] CH_GAP = "-";

  // Characters the block recognizes, drawn for most random events.
  localparam logic [7:0] KNOWN_CHARS [9] = '{"A", "C", "G", "T", "-", "a", "c", "g", "t"};

  localparam result_t QUIET     = '0;
  localparam result_t BAD_BASE  = result_t'{8'd0, 16'd0, 16'd0, 1'b0, ERR_BASE};
  localparam result_t BAD_RANGE = result_t'{8'd0, 16'd0, 16'd0, 1'b0, ERR_RANGE};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;

  always #1 clk = ~clk;

  pileup_base_counter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Model of the pileup table. Bit arrays start at zero, which matches the
  // table after the clearing pass.
  bit   [15:0] base_tally [MAX_REF_LEN][NUM_BASES];
  bit   [15:0] depth_tally [MAX_REF_LEN];
  bit          mm_flag [MAX_REF_LEN];
  logic [12:0] len_model = REF_LEN_RESET;

  // Calls still owed by the block, oldest first.
  result_t pending_calls[$];

  // A directed row may carry its own typed expectation; the driver hands it to
  // the monitor together with the beat.
  bit      typed_ok = 1'b0;
  result_t typed_res = '0;

  // When set, neither side idles.
  bit calm = 1'b0;
  int errors = 0;
  int idle_cycles = 0;

  function automatic logic [2:0] char_slot(input logic [7:0] ch);
    case (ch)
      "A", "a": return BASE_A;
      "C", "c": return BASE_C;
      "G", "g": return BASE_G;
      "T", "t": return BASE_T;
      "-":      return BASE_GAP;
      default:  return BASE_NONE;
    endcase
  endfunction

  function automatic logic [7:0] slot_char(input logic [2:0] slot);
    case (slot)
      BASE_A:  return CH_A;
      BASE_C:  return CH_C;
      BASE_G:  return CH_G;
      BASE_T:  return CH_T;
      default: return CH_GAP;
    endcase
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Applies one event to the model table and returns the call the block owes for it.
  function automatic result_t pileup_update(input logic [2:0] kind, input logic [11:0] pos,
                                            input logic [7:0] ch);
    result_t     call;
    logic [2:0]  slot;
    logic [2:0]  best;
    logic [15:0] top;
    int          lim;
    call = '0;
    lim  = (len_model < 13'(MAX_REF_LEN)) ? int'(len_model) : MAX_REF_LEN;
    if (kind > REQ_CLEAR) return call;
    // The range check wins over a bad character.
    if (int'(pos) >= lim) begin
      call.err = ERR_RANGE;
      return call;
    end
    slot = char_slot(ch);
    case (kind)
      REQ_MATCH, REQ_MISMATCH: begin
        if (slot == BASE_NONE) begin
          call.err = ERR_BASE;
        end else begin
          base_tally[pos][slot] = bump(base_tally[pos][slot]);
          depth_tally[pos] = bump(depth_tally[pos]);
          if (kind == REQ_MISMATCH) mm_flag[pos] = 1'b1;
        end
      end
      REQ_DELETION: begin
        base_tally[pos][BASE_GAP] = bump(base_tally[pos][BASE_GAP]);
        depth_tally[pos] = bump(depth_tally[pos]);
        mm_flag[pos] = 1'b1;
      end
      REQ_SKIP: begin
        depth_tally[pos] = bump(depth_tally[pos]);
      end
      REQ_READOUT: begin
        if (slot == BASE_NONE) begin
          call.err = ERR_BASE;
        end else begin
          // Start from the reference base so that it keeps every tie.
          best = slot;
          top  = base_tally[pos][slot];
          for (int i = 0; i < NUM_BASES; i++) begin
            if (base_tally[pos][i] > top) begin
              top  = base_tally[pos][i];
              best = 3'(i);
            end
          end
          call.base  = slot_char(best);
          call.count = top;
          call.cov   = depth_tally[pos];
          call.mark  = mm_flag[pos];
        end
      end
      default: begin
        for (int i = 0; i < NUM_BASES; i++) base_tally[pos][i] = '0;
        depth_tally[pos] = '0;
        mm_flag[pos] = 1'b0;
      end
    endcase
    return call;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Scoreboard: every accepted input beat owes exactly one output beat, in order.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = pileup_update(in_tuser, in_tdata[11:0], in_tdata[19:12]);
        if (typed_ok) want = typed_res;
        pending_calls = {pending_calls, want};
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tdata[23:8], out_tdata[39:24], out_tdata[40], out_tuser};
        if (pending_calls.size() == 0) begin
          $error("output beat with nothing outstanding: tdata %0h, tuser %0h",
                 out_tdata, out_tuser);
          errors++;
        end else begin
          want = pending_calls.pop_front();
          check_field("consensus_base", 16'(want.base), 16'(got.base));
          check_field("consensus_count", want.count, got.count);
          check_field("coverage", want.cov, got.cov);
          check_field("mismatch_mark", 16'(want.mark), 16'(got.mark));
          check_field("error_code", 16'(want.err), 16'(got.err));
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("pileup_base_counter verification failed");
      $finish;
    end
  end

  // The result side stalls in about 16 percent of cycles unless the run is calm.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 16);
  end

  // Offers one beat at the falling edge and holds it until the block takes it.
  // Valid stays high into the next call unless that call opens a gap.
  task automatic send_beat(input logic [2:0] kind, input logic [11:0] pos, input logic [7:0] ch,
                           input bit typed = 1'b0, input result_t want = '0);
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {4'd0, ch, pos};
    typed_ok  = typed;
    typed_res = want;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // Lets every owed call come back and the last write-back finish.
  task automatic drain;
    in_tvalid = 1'b0;
    typed_ok  = 1'b0;
    while (pending_calls.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // The length register changes only with the block idle.
  task automatic set_length(input logic [12:0] len);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = len;
    len_model   = len;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Random traffic. Most events land in a window of eight positions so that
  // counts pile up and readouts see real contests; the rest hit anywhere or
  // right at the current length limit.
  task automatic random_traffic(input int beats);
    int          lim;
    int          hot;
    int          roll;
    int          p;
    logic [2:0]  kind;
    logic [7:0]  ch;
    lim = (len_model < 13'(MAX_REF_LEN)) ? int'(len_model) : MAX_REF_LEN;
    hot = (lim > 8) ? $urandom_range(0, lim - 8) : 0;
    repeat (beats) begin
      roll = $urandom_range(0, 99);
      if (roll < 30)      kind = REQ_MATCH;
      else if (roll < 45) kind = REQ_MISMATCH;
      else if (roll < 55) kind = REQ_DELETION;
      else if (roll < 63) kind = REQ_SKIP;
      else if (roll < 88) kind = REQ_READOUT;
      else if (roll < 94) kind = REQ_CLEAR;
      else                kind = $urandom_range(0, 1) ? REQ_SPARE7 : REQ_SPARE6;
      roll = $urandom_range(0, 99);
      if (roll < 70)      p = hot + $urandom_range(0, 7);
      else if (roll < 85) p = $urandom_range(0, MAX_REF_LEN - 1);
      else                p = lim + $urandom_range(0, 3) - 2;
      if (p < 0) p = 0;
      if (p > MAX_REF_LEN - 1) p = MAX_REF_LEN - 1;
      if ($urandom_range(0, 99) < 80) ch = KNOWN_CHARS[$urandom_range(0, 8)];
      else                            ch = 8'($urandom_range(0, 255));
      send_beat(kind, 12'(p), ch);
    end
  endtask

  // One row of the directed table. A row may first change the length register.
  typedef struct {
    bit          relen;
    logic [12:0] len;
    logic [2:0]  kind;
    logic [11:0] pos;
    logic [7:0]  ch;
    bit          typed;
    result_t     want;
  } plan_row_t;

  plan_row_t directed[$];

  task automatic plan_row(input bit relen, input logic [12:0] len, input logic [2:0] kind,
                          input logic [11:0] pos, input logic [7:0] ch, input bit typed,
                          input result_t want);
    plan_row_t row;
    row.relen = relen;
    row.len   = len;
    row.kind  = kind;
    row.pos   = pos;
    row.ch    = ch;
    row.typed = typed;
    row.want  = want;
    directed = {directed, row};
  endtask

  initial begin
    // Fresh table: readouts return the reference base with zero counts,
    // lower case included.
    plan_row(0, 0, REQ_READOUT,  12'd0,    "A",   1, result_t'{CH_A, 16'd0, 16'd0, 1'b0, ERR_OK});
    plan_row(0, 0, REQ_READOUT,  12'd4095, "g",   1, result_t'{CH_G, 16'd0, 16'd0, 1'b0, ERR_OK});
    // Every event kind at the top position; deletion and skip ignore the character.
    plan_row(0, 0, REQ_MATCH,    12'd4095, "T",   1, QUIET);
    plan_row(0, 0, REQ_MISMATCH, 12'd4095, "c",   1, QUIET);
    plan_row(0, 0, REQ_DELETION, 12'd4095, 8'hFF, 1, QUIET);
    plan_row(0, 0, REQ_SKIP,     12'd4095, 8'h00, 1, QUIET);
    plan_row(0, 0, REQ_READOUT,  12'd4095, "A",   0, QUIET);
    // Unknown characters are flagged and leave the table alone.
    plan_row(0, 0, REQ_MATCH,    12'd10,   8'h00, 1, BAD_BASE);
    plan_row(0, 0, REQ_MISMATCH, 12'd10,   8'hFF, 1, BAD_BASE);
    plan_row(0, 0, REQ_READOUT,  12'd10,   "x",   1, BAD_BASE);
    plan_row(0, 0, REQ_READOUT,  12'd10,   "-",   1, result_t'{CH_GAP, 16'd0, 16'd0, 1'b0, ERR_OK});
    plan_row(0, 0, REQ_MISMATCH, 12'd10,   "-",   1, QUIET);
    plan_row(0, 0, REQ_MATCH,    12'd10,   "a",   1, QUIET);
    plan_row(0, 0, REQ_READOUT,  12'd10,   "t",   0, QUIET);
    // Clearing a position brings it back to the fresh state.
    plan_row(0, 0, REQ_CLEAR,    12'd4095, 8'hAA, 1, QUIET);
    plan_row(0, 0, REQ_READOUT,  12'd4095, "t",   1, result_t'{CH_T, 16'd0, 16'd0, 1'b0, ERR_OK});
    // The two unused request kinds do nothing.
    plan_row(0, 0, REQ_SPARE6,   12'd5,    "A",   1, QUIET);
    plan_row(0, 0, REQ_SPARE7,   12'd4095, 8'hFF, 1, QUIET);
    // A zero length rejects everything; with a length of one the range error
    // beats a bad character, and an unused kind stays silent even out of range.
    plan_row(1, 13'd0, REQ_MATCH,    12'd0,    "A",   1, BAD_RANGE);
    plan_row(1, 13'd1, REQ_READOUT,  12'd1,    "x",   1, BAD_RANGE);
    plan_row(0, 0,     REQ_MATCH,    12'd0,    "C",   1, QUIET);
    plan_row(0, 0,     REQ_READOUT,  12'd0,    "G",   0, QUIET);
    plan_row(0, 0,     REQ_SPARE6,   12'd4095, 8'h00, 1, QUIET);
    // Lengths beyond the table size are capped at the table size.
    plan_row(1, 13'd8191, REQ_READOUT,  12'd4095, "Z", 1, BAD_BASE);
    plan_row(1, 13'd4096, REQ_DELETION, 12'd4095, "q", 1, QUIET);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].relen) set_length(directed[i].len);
      send_beat(directed[i].kind, directed[i].pos, directed[i].ch,
                directed[i].typed, directed[i].want);
    end

    // Random phases: first a stretch with no idling, then idling on both sides,
    // under short, single, oversized, zero and ordinary lengths.
    calm = 1'b1;
    random_traffic(100);
    calm = 1'b0;
    random_traffic(100);
    set_length(13'd100);
    random_traffic(120);
    set_length(13'd1);
    random_traffic(60);
    set_length(13'd8191);
    random_traffic(150);
    set_length(13'd0);
    random_traffic(30);
    set_length(13'd3000);
    random_traffic(140);

    drain();
    if (errors == 0) begin
      $display("pileup_base_counter verification clean");
    end else begin
      $display("pileup_base_counter verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pbc_pkg.sv
rtl/core/pbc_table_ram.sv
rtl/core/pbc_update.sv
rtl/core/pileup_base_counter.sv
tb/sv/pileup_base_counter_tb.sv
